>>> hw/rtl/frsff_pkg.sv
// Package with sizes, table entry type, state encoding and control structs of the filter.
package frsff_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef struct packed {
    logic [63:0] device_id;
    logic [63:0] inode_number;
    logic [62:0] file_size;
    logic [63:0] modify_time;
  } ident_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic insert;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/frsff_ctrl.sv
// Controller state machine that sequences load, table scan, insert and result hand-off.
module frsff_ctrl
  import frsff_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.hit || status.exhausted) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.insert = status.exhausted && !status.hit;
      end
      ST_RESULT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

>>> hw/rtl/frsff_datapath.sv
// Datapath with the identity table memory, scan counter, compare, insert pointer and result register.
module frsff_datapath
  import frsff_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd,
  input  ident_t  in_ident,
  input  logic    out_stall,
  output status_t status,
  output logic    out_valid,
  output logic    out_seen_before
);

  ident_t mem [TABLE_ENTRIES];

  ident_t           key_r;
  ident_t           rdata_r;
  logic [CNT_W-1:0] scan_idx_r;
  logic [CNT_W-1:0] fill_r;
  logic [IDX_W-1:0] ptr_r;
  logic             rd_pend_r;
  logic             seen_r;
  logic             out_valid_r;
  logic             out_seen_r;
  logic             rd_en;

  assign rd_en = cmd.scan && (scan_idx_r < fill_r);

  assign status.hit       = rd_pend_r && (rdata_r == key_r);
  assign status.exhausted = !rd_pend_r && (scan_idx_r >= fill_r);
  assign status.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[scan_idx_r[IDX_W-1:0]];
    end
    if (cmd.insert) begin
      mem[ptr_r] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_ident;
    end
    if (cmd.scan && status.hit) begin
      seen_r <= 1'b1;
    end else if (cmd.insert) begin
      seen_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_seen_r <= seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r  <= '0;
      fill_r      <= '0;
      ptr_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx_r <= '0;
        rd_pend_r  <= 1'b0;
      end else if (cmd.scan) begin
        rd_pend_r <= rd_en;
        if (rd_en) begin
          scan_idx_r <= scan_idx_r + CNT_W'(1);
        end
      end
      if (cmd.insert) begin
        if (ptr_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          ptr_r <= '0;
        end else begin
          ptr_r <= ptr_r + IDX_W'(1);
        end
        if (fill_r != CNT_W'(TABLE_ENTRIES)) begin
          fill_r <= fill_r + CNT_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seen_before = out_seen_r;

endmodule

>>> hw/rtl/fifo_replaced_seen_file_filter_top.sv
// Top level of the seen-before file identity filter with round-robin replacement.
//
// The input channel carries one file identity per item: device, inode, size
// and modification time. The result channel returns one seen_before bit per
// item, in order. Both channels use valid and stall.
// An item is taken only while the block is idle. The table scan then reads one
// stored entry per cycle from a single-port memory, covering the filled entries
// (at most 1024). A hit ends the scan early. A miss writes the identity into
// the slot at the insert pointer, which then advances with wrap, replacing the
// oldest entry. The result sits in an output register, so a new item is
// accepted while an earlier result still waits. If the receiver stalls, a
// finished result waits in the controller until the output register is free.
// Reset empties the table at once through the fill count and sets the insert
// pointer to slot zero; no clearing pass is needed.
module fifo_replaced_seen_file_filter_top
  import frsff_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [63:0] in_device_id,
  input  logic        [63:0] in_inode_number,
  input  logic        [62:0] in_file_size,
  input  logic signed [63:0] in_modify_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_seen_before
);

  cmd_t    cmd;
  status_t status;
  ident_t  in_ident;
  logic    busy;

  assign in_ident.device_id    = in_device_id;
  assign in_ident.inode_number = in_inode_number;
  assign in_ident.file_size    = in_file_size;
  assign in_ident.modify_time  = in_modify_time;
  assign in_stall              = busy;

  frsff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  frsff_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_ident        (in_ident),
    .out_stall       (out_stall),
    .status          (status),
    .out_valid       (out_valid),
    .out_seen_before (out_seen_before)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took an item but did not become busy");

  a_insert_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !status.hit)
    else $error("insert issued while a matching entry was found");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending result");

endmodule

>>> tb/seen_filter_checker.sv
`timescale 1ns / 1ps
// Checker that predicts seen_before for every accepted identity and compares the results.
module seen_filter_checker
  import frsff_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic        [63:0] in_device_id,
  input  logic        [63:0] in_inode_number,
  input  logic        [62:0] in_file_size,
  input  logic signed [63:0] in_modify_time,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_seen_before,
  output int                 fail_count,
  output int                 due_count
);

  localparam int PRINT_LIMIT = 100;

  ident_t      known_ident [TABLE_ENTRIES];
  logic        known_valid [TABLE_ENTRIES];
  int unsigned next_slot;
  logic        seen_before_due [$];
  int          result_index;
  logic        wanted;

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_LIMIT) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
    fail_count++;
  endtask

  function automatic logic lookup_or_insert(input ident_t id);
    for (int s = 0; s < TABLE_ENTRIES; s++) begin
      if (known_valid[s] && known_ident[s] == id) begin
        return 1'b1;
      end
    end
    known_ident[next_slot] = id;
    known_valid[next_slot] = 1'b1;
    next_slot = (next_slot + 1) % TABLE_ENTRIES;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < TABLE_ENTRIES; s++) begin
        known_valid[s] = 1'b0;
      end
      next_slot = 0;
      result_index = 0;
      seen_before_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (seen_before_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item waiting for it",
                                    result_index));
        end else begin
          wanted = seen_before_due.pop_front();
          if (out_seen_before !== wanted) begin
            report_mismatch($sformatf("result %0d: seen_before %b, expected %b",
                                      result_index, out_seen_before, wanted));
          end
        end
        result_index++;
      end
      if (in_valid && !in_stall) begin
        seen_before_due.push_back(lookup_or_insert({in_device_id, in_inode_number,
                                                    in_file_size, in_modify_time}));
      end
    end
    due_count <= seen_before_due.size();
  end

endmodule

>>> tb/tb_fifo_replaced_seen_file_filter_top.sv
`timescale 1ns / 1ps
// Testbench top that drives file identities into the seen-before filter and reports the verdict.
module tb_fifo_replaced_seen_file_filter_top;
  import frsff_pkg::*;

  localparam int RANDOM_ITEMS = 524;
  localparam int TAIL_ITEMS   = 40;
  localparam int HOLD_AFTER   = 16;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 1100;
  localparam int CYCLE_LIMIT  = 5000000;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic        [63:0] in_device_id    = '0;
  logic        [63:0] in_inode_number = '0;
  logic        [62:0] in_file_size    = '0;
  logic signed [63:0] in_modify_time  = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic               out_seen_before;

  int     fail_count;
  int     due_count;
  int     cycle_count = 0;
  int     send_calm   = 0;
  ident_t sent_history [$];

  fifo_replaced_seen_file_filter_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_device_id    (in_device_id),
    .in_inode_number (in_inode_number),
    .in_file_size    (in_file_size),
    .in_modify_time  (in_modify_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_seen_before (out_seen_before)
  );

  seen_filter_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_device_id    (in_device_id),
    .in_inode_number (in_inode_number),
    .in_file_size    (in_file_size),
    .in_modify_time  (in_modify_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_seen_before (out_seen_before),
    .fail_count      (fail_count),
    .due_count       (due_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic ident_t make_ident(input logic [63:0] dev, input logic [63:0] ino,
                                        input logic [62:0] len, input logic [63:0] mtime);
    return {dev, ino, len, mtime};
  endfunction

  function automatic ident_t fresh_ident();
    logic [255:0] bits;
    bits = {rand64(), rand64(), rand64(), rand64()};
    return bits[254:0];
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_ident(input ident_t id);
    int gap;
    gap = idle_len(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_device_id    <= id.device_id;
    in_inode_number <= id.inode_number;
    in_file_size    <= id.file_size;
    in_modify_time  <= id.modify_time;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_history.push_back(id);
  endtask

  // The receiver holds off once for a long stretch so that the block backs up.
  initial begin : result_sink
    int   stall_left;
    int   taken;
    int   calm;
    logic held;
    stall_left = 0;
    taken = 0;
    calm = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      if (!held && taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_len(calm);
      end
    end
  end

  initial begin : identity_source
    ident_t      id;
    int          pick;
    int          flip;
    logic [63:0] small_mtime;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The all-zero identity must miss first and hit only once stored.
    send_ident(make_ident('0, '0, '0, '0));
    send_ident(make_ident('0, '0, '0, '0));
    send_ident(make_ident('1, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF));
    send_ident(make_ident('1, '1, '1, 64'h8000_0000_0000_0000));
    send_ident(make_ident('1, '1, '1, '1));
    send_ident(make_ident('1, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF));
    send_ident(make_ident(64'h8000_0000_0000_0000, '0, '0, '0));
    send_ident(make_ident('0, 64'h8000_0000_0000_0000, '0, '0));
    send_ident(make_ident('0, '0, 63'h4000_0000_0000_0000, '0));
    send_ident(make_ident('0, '0, '0, 64'd1));
    send_ident(make_ident(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                          63'h2AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
    send_ident(make_ident(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                          63'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
    send_ident(sent_history[6]);
    send_ident(sent_history[8]);
    send_ident(sent_history[11]);
    send_ident(sent_history[0]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        id = fresh_ident();
      end else if (pick < 80) begin
        id = sent_history[$urandom_range(0, sent_history.size() - 1)];
      end else if (pick < 90) begin
        id = sent_history[$urandom_range(0, sent_history.size() - 1)];
        flip = $urandom_range(0, $bits(ident_t) - 1);
        id[flip] = ~id[flip];
      end else begin
        small_mtime = $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF
                                           : 64'($urandom_range(0, 1));
        id = make_ident(64'($urandom_range(0, 1)), 64'($urandom_range(0, 3)),
                        63'($urandom_range(0, 1)), small_mtime);
      end
      send_ident(id);
    end

    // Probe early identities and recent ones once more.
    for (int n = 0; n < TAIL_ITEMS; n++) begin
      if ($urandom_range(0, 1)) begin
        id = sent_history[$urandom_range(0, 119)];
      end else begin
        id = sent_history[sent_history.size() - 1 - $urandom_range(0, 199)];
      end
      send_ident(id);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
